/* rtl/core/clcd_pkg.sv */
`timescale 1ns / 1ps

package clcd_pkg;

   // Request codes
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_DATA  = 2'd1;
   localparam logic [1:0] CMD_INSTR = 2'd2;
   localparam logic [1:0] CMD_POS   = 2'd3;

   // Configuration register indexes
   localparam logic CSR_ENABLE_TICKS  = 1'b0;
   localparam logic CSR_POWERUP_TICKS = 1'b1;

   localparam int unsigned CSR_DATA_WIDTH = 20;
   localparam int unsigned COUNT_WIDTH    = 20;

   localparam logic [7:0]  ENABLE_TICKS_RESET  = 8'd1;
   localparam logic [19:0] POWERUP_TICKS_RESET = 20'd15000;

   // Display instruction bits
   localparam logic [7:0] LCD_FUNCTION_SET = 8'h20;
   localparam logic [7:0] LCD_BUS_8BIT     = 8'h10;
   localparam logic [7:0] LCD_TWO_LINES    = 8'h08;
   localparam logic [7:0] LCD_DISPLAY_CTRL = 8'h08;
   localparam logic [7:0] LCD_DISPLAY_ON   = 8'h04;
   localparam logic [7:0] LCD_CLEAR        = 8'h01;
   localparam logic [7:0] LCD_ENTRY_MODE   = 8'h04;
   localparam logic [7:0] LCD_INCREMENT    = 8'h02;
   localparam logic [7:0] LCD_SET_ADDRESS  = 8'h80;

   localparam logic [7:0] LINE0_BASE = 8'h00;
   localparam logic [7:0] LINE1_BASE = 8'h40;
   localparam logic [7:0] LINE2_BASE = 8'h14;
   localparam logic [7:0] LINE3_BASE = 8'h54;

   localparam logic [2:0] INIT_COUNT = 3'd4;

   typedef enum logic [5:0] {
      PH_POWERUP = 6'b000001,
      PH_W_HIGH  = 6'b000010,
      PH_W_LOW   = 6'b000100,
      PH_R_HIGH  = 6'b001000,
      PH_R_LOW   = 6'b010000,
      PH_IDLE    = 6'b100000
   } phase_type;

   // Controller to datapath
   typedef struct packed {
      logic count_en;
      logic use_powerup;
      logic start_init;
      logic start_req;
      logic set_read;
      logic sample_busy;
   } clcd_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic count_done;
      logic busy_seen;
      logic init_more;
   } clcd_status_type;

   // Phase-derived pin qualifiers
   typedef struct packed {
      logic writing;
      logic strobe;
      logic idle;
      logic accepted;
   } clcd_view_type;

   // Held transfer contents
   typedef struct packed {
      logic       select;
      logic       rw_level;
      logic [7:0] data_byte;
   } clcd_bus_type;

   function automatic logic [7:0] init_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0: b = LCD_FUNCTION_SET | LCD_BUS_8BIT | LCD_TWO_LINES;
         2'd1: b = LCD_DISPLAY_CTRL | LCD_DISPLAY_ON;
         2'd2: b = LCD_CLEAR;
         2'd3: b = LCD_ENTRY_MODE | LCD_INCREMENT;
         default: b = LCD_CLEAR;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] line_base(input logic [1:0] line_sel);
      logic [7:0] b;
      case (line_sel)
         2'd0: b = LINE0_BASE;
         2'd1: b = LINE1_BASE;
         2'd2: b = LINE2_BASE;
         2'd3: b = LINE3_BASE;
         default: b = LINE0_BASE;
      endcase
      return b;
   endfunction

endpackage

/* rtl/core/clcd_channel_if.sv */
`timescale 1ns / 1ps

interface clcd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] value;
   logic [1:0] line;
   logic [5:0] column;
   logic [7:0] bus_in;

   modport source (output valid, command, value, line, column, bus_in, input ready);
   modport sink   (input valid, command, value, line, column, bus_in, output ready);
endinterface

interface clcd_rsp_if;
   logic       valid;
   logic       ready;
   logic       pin_rs;
   logic       pin_rw;
   logic       pin_e;
   logic [7:0] data_out;
   logic       data_drive;
   logic       ready_res;
   logic       accepted;

   modport source (output valid, pin_rs, pin_rw, pin_e, data_out, data_drive, ready_res,
                   accepted, input ready);
   modport sink   (input valid, pin_rs, pin_rw, pin_e, data_out, data_drive, ready_res,
                   accepted, output ready);
endinterface

/* rtl/core/char_lcd_bus_sequencer.sv */
`timescale 1ns / 1ps
// Character LCD bus sequencer, 8-bit parallel display bus.
// req_channel carries one transaction per time tick (command tick, with the
// sampled data lines in bus_in) or one request: write a data byte, write an
// instruction byte, or set the cursor position.
// rsp_channel returns exactly one transaction per request transaction: the pin
// levels after that item (RS, RW, E, driven byte, drive enable), whether the
// sequencer is idle, and whether the request was taken. Requests that come
// while the power-up wait, a transfer or a busy poll is running are answered
// with accepted low. Each item is handled by the phase controller and the
// counter datapath; its response is registered and appears in the cycle after
// acceptance, so one transaction per clock is sustained while the receiver
// keeps rsp ready high. If the receiver stalls, the response register holds
// and req ready drops until it is taken; nothing is lost or repeated.
// Reset starts the power-up wait (powerup_ticks ticks), after which the four
// initialization instructions go out, each followed by busy polling.
// csr_write_enable/csr_index/csr_write_data set enable_ticks (index 0) and
// powerup_ticks (index 1); write them only while the sequencer is quiet.

module char_lcd_bus_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   clcd_req_if.sink                            req_channel,
   clcd_rsp_if.source                          rsp_channel,
   input  logic                                csr_write_enable,
   input  logic                                csr_index,
   input  logic [clcd_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);
   import clcd_pkg::*;

   clcd_cmd_type    dp_cmd;
   clcd_status_type dp_status;
   clcd_view_type   view;
   clcd_bus_type    pend;
   logic            rsp_valid;
   logic            req_ready;

   // Phase sequencing and the response handshake
   clcd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_channel.valid),
      .req_command (req_channel.command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_channel.ready),
      .dp_status   (dp_status),
      .dp_cmd      (dp_cmd),
      .view        (view)
   );

   // Timing counter, held byte, init index, busy sample, configuration
   clcd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_command      (req_channel.command),
      .req_value        (req_channel.value),
      .req_line         (req_channel.line),
      .req_column       (req_channel.column),
      .req_bus_in       (req_channel.bus_in),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .pend             (pend)
   );

   assign req_channel.ready = req_ready;
   assign rsp_channel.valid = rsp_valid;

   // Drive the byte and RS only while a write is on the bus; RW keeps its
   // last level between transfers.
   assign rsp_channel.pin_rs     = view.writing & pend.select;
   assign rsp_channel.pin_rw     = pend.rw_level;
   assign rsp_channel.pin_e      = view.strobe;
   assign rsp_channel.data_out   = view.writing ? pend.data_byte : 8'h00;
   assign rsp_channel.data_drive = view.writing;
   assign rsp_channel.ready_res  = view.idle;
   assign rsp_channel.accepted   = view.accepted;

   // A taken request always starts with E high and the byte driven
   a_accept_starts_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && view.accepted |-> view.writing && view.strobe)
      else $error("taken request did not start a write");

   // Never drive the data lines while reading the status
   a_no_drive_on_read: assert property (@(posedge clock) disable iff (reset)
      view.writing |-> !pend.rw_level)
      else $error("data lines driven during a read");

   // A request that finds the sequencer idle is taken
   a_idle_request_taken: assert property (@(posedge clock) disable iff (reset)
      req_channel.valid && req_ready && (req_channel.command != CMD_TICK) && view.idle
      |=> view.accepted && rsp_valid)
      else $error("idle request was refused");

endmodule

/* rtl/core/clcd_ctrl.sv */
`timescale 1ns / 1ps

module clcd_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [1:0]                 req_command,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  clcd_pkg::clcd_status_type  dp_status,
   output clcd_pkg::clcd_cmd_type     dp_cmd,
   output clcd_pkg::clcd_view_type    view
);
   import clcd_pkg::*;

   phase_type phase_ff, phase_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accepted_ff, accepted_in;
   logic      accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      phase_in    = phase_ff;
      accepted_in = accepted_ff;
      dp_cmd      = '0;
      if (accept) begin
         accepted_in = 1'b0;
         if (req_command == CMD_TICK) begin
            case (phase_ff)
               PH_POWERUP: begin
                  dp_cmd.count_en    = 1'b1;
                  dp_cmd.use_powerup = 1'b1;
                  if (dp_status.count_done) begin
                     dp_cmd.start_init = 1'b1;
                     phase_in          = PH_W_HIGH;
                  end
               end
               PH_W_HIGH: begin
                  dp_cmd.count_en = 1'b1;
                  if (dp_status.count_done) begin
                     phase_in = PH_W_LOW;
                  end
               end
               PH_W_LOW: begin
                  dp_cmd.count_en = 1'b1;
                  if (dp_status.count_done) begin
                     dp_cmd.set_read = 1'b1;
                     phase_in        = PH_R_HIGH;
                  end
               end
               PH_R_HIGH: begin
                  dp_cmd.count_en = 1'b1;
                  if (dp_status.count_done) begin
                     dp_cmd.sample_busy = 1'b1;
                     phase_in           = PH_R_LOW;
                  end
               end
               PH_R_LOW: begin
                  dp_cmd.count_en = 1'b1;
                  if (dp_status.count_done) begin
                     if (dp_status.busy_seen) begin
                        phase_in = PH_R_HIGH;
                     end else if (dp_status.init_more) begin
                        dp_cmd.start_init = 1'b1;
                        phase_in          = PH_W_HIGH;
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
               end
               PH_IDLE: begin
                  phase_in = PH_IDLE;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end else if (phase_ff == PH_IDLE) begin
            accepted_in      = 1'b1;
            dp_cmd.start_req = 1'b1;
            phase_in         = PH_W_HIGH;
         end
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_POWERUP;
         rsp_valid_ff <= 1'b0;
         accepted_ff  <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         accepted_ff  <= accepted_in;
      end
   end

   assign view.writing  = (phase_ff == PH_W_HIGH) || (phase_ff == PH_W_LOW);
   assign view.strobe   = (phase_ff == PH_W_HIGH) || (phase_ff == PH_R_HIGH);
   assign view.idle     = (phase_ff == PH_IDLE);
   assign view.accepted = accepted_ff;

endmodule

/* rtl/core/clcd_datapath.sv */
`timescale 1ns / 1ps

module clcd_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic                                  csr_index,
   input  logic [clcd_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   input  logic [1:0]                            req_command,
   input  logic [7:0]                            req_value,
   input  logic [1:0]                            req_line,
   input  logic [5:0]                            req_column,
   input  logic [7:0]                            req_bus_in,
   input  clcd_pkg::clcd_cmd_type                dp_cmd,
   output clcd_pkg::clcd_status_type             dp_status,
   output clcd_pkg::clcd_bus_type                pend
);
   import clcd_pkg::*;

   logic [7:0]             enable_ticks_ff;
   logic [19:0]            powerup_ticks_ff;
   logic [COUNT_WIDTH-1:0] wait_count_ff, wait_count_in;
   logic [7:0]             pending_byte_ff, pending_byte_in;
   logic                   pending_select_ff, pending_select_in;
   logic [2:0]             init_index_ff, init_index_in;
   logic                   rw_level_ff, rw_level_in;
   logic                   busy_seen_ff, busy_seen_in;

   logic [COUNT_WIDTH-1:0] wait_inc;
   logic [COUNT_WIDTH-1:0] limit;
   logic [7:0]             req_byte;
   logic                   req_select;

   // A zero limit behaves as one
   always_comb begin
      limit = dp_cmd.use_powerup ? powerup_ticks_ff : {12'd0, enable_ticks_ff};
      if (limit == '0) begin
         limit = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
      end
   end

   assign wait_inc             = wait_count_ff + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
   assign dp_status.count_done = (wait_inc >= limit);
   assign dp_status.busy_seen  = busy_seen_ff;
   assign dp_status.init_more  = (init_index_ff < INIT_COUNT);

   always_comb begin
      case (req_command)
         CMD_DATA: begin
            req_byte   = req_value;
            req_select = 1'b1;
         end
         CMD_INSTR: begin
            req_byte   = req_value;
            req_select = 1'b0;
         end
         CMD_POS: begin
            req_byte   = LCD_SET_ADDRESS + line_base(req_line) + {2'b00, req_column};
            req_select = 1'b0;
         end
         default: begin
            req_byte   = req_value;
            req_select = 1'b0;
         end
      endcase
   end

   always_comb begin
      wait_count_in     = wait_count_ff;
      pending_byte_in   = pending_byte_ff;
      pending_select_in = pending_select_ff;
      init_index_in     = init_index_ff;
      rw_level_in       = rw_level_ff;
      busy_seen_in      = busy_seen_ff;

      if (dp_cmd.count_en) begin
         wait_count_in = dp_status.count_done ? '0 : wait_inc;
      end
      if (dp_cmd.set_read) begin
         rw_level_in = 1'b1;
      end
      if (dp_cmd.sample_busy) begin
         busy_seen_in = req_bus_in[7];
      end
      if (dp_cmd.start_init) begin
         pending_byte_in   = init_byte(init_index_ff[1:0]);
         pending_select_in = 1'b0;
         init_index_in     = init_index_ff + 3'd1;
         rw_level_in       = 1'b0;
         wait_count_in     = '0;
      end
      if (dp_cmd.start_req) begin
         pending_byte_in   = req_byte;
         pending_select_in = req_select;
         rw_level_in       = 1'b0;
         wait_count_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ticks_ff   <= ENABLE_TICKS_RESET;
         powerup_ticks_ff  <= POWERUP_TICKS_RESET;
         wait_count_ff     <= '0;
         pending_byte_ff   <= '0;
         pending_select_ff <= 1'b0;
         init_index_ff     <= '0;
         rw_level_ff       <= 1'b0;
         busy_seen_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ENABLE_TICKS:  enable_ticks_ff  <= csr_write_data[7:0];
               CSR_POWERUP_TICKS: powerup_ticks_ff <= csr_write_data[19:0];
               default:           enable_ticks_ff  <= enable_ticks_ff;
            endcase
         end
         wait_count_ff     <= wait_count_in;
         pending_byte_ff   <= pending_byte_in;
         pending_select_ff <= pending_select_in;
         init_index_ff     <= init_index_in;
         rw_level_ff       <= rw_level_in;
         busy_seen_ff      <= busy_seen_in;
      end
   end

   assign pend.select    = pending_select_ff;
   assign pend.rw_level  = rw_level_ff;
   assign pend.data_byte = pending_byte_ff;

endmodule

/* tb/char_lcd_bus_sequencer_tb.sv */
`timescale 1ns / 1ps

module char_lcd_bus_sequencer_tb;
   import clcd_pkg::*;

   // One request-channel transaction as the sequencer sees it
   typedef struct packed {
      logic [1:0] command;
      logic [7:0] value;
      logic [1:0] line;
      logic [5:0] column;
      logic [7:0] bus_in;
   } lcd_request_type;

   // One response-channel transaction: pin levels after the item
   typedef struct packed {
      logic       rs;
      logic       rw;
      logic       e;
      logic [7:0] data_out;
      logic       drive;
      logic       ready_res;
      logic       accepted;
   } lcd_pins_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // Directed table row: either a request-channel transaction, optionally with a
   // hand-written expected response, or a register write done while quiet
   typedef struct packed {
      row_kind_type    kind;
      lcd_request_type item;
      logic            typed;
      lcd_pins_type    pins;
      logic            csr_sel;
      logic [19:0]     csr_value;
   } step_row_type;

   localparam lcd_pins_type PINS_QUIET = '0;
   localparam logic [7:0] INIT_SEQ [4] = '{8'h38, 8'h0C, 8'h01, 8'h06};
   localparam logic [7:0] LINE_BASES [4] = '{8'h00, 8'h40, 8'h14, 8'h54};
   localparam int NUM_DIRECTED = 32;

   // Walk through the power-up wait, the init sequence with one busy repeat,
   // a refused request, and an address that wraps past 0xFF.
   step_row_type directed_steps [NUM_DIRECTED] = '{
      // park the power-up count at its maximum, poke it, then cut it to zero
      '{ROW_CSR, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b0, PINS_QUIET,
        CSR_POWERUP_TICKS, 20'hFFFFF},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'hFF}, 1'b1, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_DATA, 8'hA5, 2'd0, 6'd0, 8'h00}, 1'b1, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_CSR, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b0, PINS_QUIET,
        CSR_POWERUP_TICKS, 20'h0},
      // count already past the zero limit: first init byte goes out at once
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h80}, 1'b1,
        '{1'b0, 1'b0, 1'b1, 8'h38, 1'b1, 1'b0, 1'b0}, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'hFF}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      // busy flag set on the sample tick, so the read repeats
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h80}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h7F}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      // busy bit outside the sample tick is ignored
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h80}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      // idle now: a tick does nothing
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'hFF}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_DATA, 8'hFF, 2'd0, 6'd0, 8'h00}, 1'b1,
        '{1'b1, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b1}, 1'b0, 20'h0},
      // refused while the data write runs
      '{ROW_ITEM, '{CMD_INSTR, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b1,
        '{1'b1, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0}, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      '{ROW_ITEM, '{CMD_TICK, 8'h00, 2'd0, 6'd0, 8'h00}, 1'b0, PINS_QUIET, 1'b0, 20'h0},
      // last line, last column: 0x80 + 0x54 + 0x3F wraps to 0x13
      '{ROW_ITEM, '{CMD_POS, 8'h00, 2'd3, 6'd63, 8'h00}, 1'b1,
        '{1'b0, 1'b0, 1'b1, 8'h13, 1'b1, 1'b0, 1'b1}, 1'b0, 20'h0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                      csr_write_enable;
   logic                      csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data;

   clcd_req_if req_bus ();
   clcd_rsp_if rsp_bus ();

   char_lcd_bus_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_bus),
      .rsp_channel      (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle percentages for the sender and the receiver, changed per phase
   int send_gap_pct  = 24;
   int rsp_stall_pct = 57;
   int mismatch_count = 0;

   // Expected-response side info travels with the request being driven
   logic         drv_typed = 1'b0;
   lcd_pins_type drv_pins  = '0;

   // Predicted sequencer state and register copies
   phase_type   lcd_phase;
   logic [19:0] tick_wait;
   logic [7:0]  held_byte;
   logic        held_rs;
   logic [2:0]  init_step;
   logic        rw_hold;
   logic        busy_sample;
   logic [7:0]  cfg_enable_ticks;
   logic [19:0] cfg_powerup_ticks;

   lcd_pins_type expected_pins [$];

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // Advance the level counter; a zero limit behaves as one
   function automatic logic count_expired(input logic [19:0] limit);
      logic [19:0] span;
      span = (limit == '0) ? 20'd1 : limit;
      tick_wait = tick_wait + 20'd1;
      if (tick_wait >= span) begin
         tick_wait = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void begin_write(input logic [7:0] b, input logic rs);
      held_byte = b;
      held_rs   = rs;
      rw_hold   = 1'b0;
      tick_wait = '0;
      lcd_phase = PH_W_HIGH;
   endfunction

   function automatic void advance_tick(input logic [7:0] bus);
      case (lcd_phase)
         PH_POWERUP: begin
            if (count_expired(cfg_powerup_ticks)) begin
               init_step = 3'd1;
               begin_write(INIT_SEQ[0], 1'b0);
            end
         end
         PH_W_HIGH: begin
            if (count_expired({12'd0, cfg_enable_ticks}))
               lcd_phase = PH_W_LOW;
         end
         PH_W_LOW: begin
            if (count_expired({12'd0, cfg_enable_ticks})) begin
               rw_hold   = 1'b1;
               lcd_phase = PH_R_HIGH;
            end
         end
         PH_R_HIGH: begin
            // sample the busy flag on the last tick of the high level
            if (count_expired({12'd0, cfg_enable_ticks})) begin
               busy_sample = bus[7];
               lcd_phase   = PH_R_LOW;
            end
         end
         PH_R_LOW: begin
            if (count_expired({12'd0, cfg_enable_ticks})) begin
               if (busy_sample) begin
                  lcd_phase = PH_R_HIGH;
               end else if (init_step < INIT_COUNT) begin
                  begin_write(INIT_SEQ[init_step[1:0]], 1'b0);
                  init_step = init_step + 3'd1;
               end else begin
                  lcd_phase = PH_IDLE;
               end
            end
         end
         default: begin
            lcd_phase = PH_IDLE;
            tick_wait = '0;
         end
      endcase
   endfunction

   // Apply one transaction to the predicted state and return the pin levels after it
   function automatic lcd_pins_type predict_pins(input lcd_request_type item);
      lcd_pins_type pins;
      logic         writing;
      logic         took;
      took = 1'b0;
      if (item.command == CMD_TICK) begin
         advance_tick(item.bus_in);
      end else if (lcd_phase == PH_IDLE) begin
         took = 1'b1;
         case (item.command)
            CMD_DATA:  begin_write(item.value, 1'b1);
            CMD_INSTR: begin_write(item.value, 1'b0);
            default:   begin_write(LCD_SET_ADDRESS + LINE_BASES[item.line] + {2'b00, item.column},
                                   1'b0);
         endcase
      end
      writing        = (lcd_phase == PH_W_HIGH) || (lcd_phase == PH_W_LOW);
      pins.rs        = writing ? held_rs : 1'b0;
      pins.rw        = rw_hold;
      pins.e         = (lcd_phase == PH_W_HIGH) || (lcd_phase == PH_R_HIGH);
      pins.data_out  = writing ? held_byte : 8'h00;
      pins.drive     = writing;
      pins.ready_res = (lcd_phase == PH_IDLE);
      pins.accepted  = took;
      return pins;
   endfunction

   // Scoreboard: register writes and accepted requests update the prediction,
   // accepted responses are checked against the oldest expectation.
   always @(posedge clock) begin : scoreboard
      lcd_pins_type predicted;
      lcd_pins_type want;
      if (reset) begin
         lcd_phase         = PH_POWERUP;
         tick_wait         = '0;
         held_byte         = '0;
         held_rs           = 1'b0;
         init_step         = '0;
         rw_hold           = 1'b0;
         busy_sample       = 1'b0;
         cfg_enable_ticks  = ENABLE_TICKS_RESET;
         cfg_powerup_ticks = POWERUP_TICKS_RESET;
         expected_pins.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ENABLE_TICKS:  cfg_enable_ticks  = csr_write_data[7:0];
               CSR_POWERUP_TICKS: cfg_powerup_ticks = csr_write_data[19:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            predicted = predict_pins({req_bus.command, req_bus.value, req_bus.line,
                                      req_bus.column, req_bus.bus_in});
            // hand-written rows override the prediction, state still advances
            expected_pins.push_back(drv_typed ? drv_pins : predicted);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_pins.size() == 0) begin
               report_mismatch("response with nothing expected");
            end else begin
               want = expected_pins.pop_front();
               check_field("pin_rs", {7'd0, rsp_bus.pin_rs}, {7'd0, want.rs});
               check_field("pin_rw", {7'd0, rsp_bus.pin_rw}, {7'd0, want.rw});
               check_field("pin_e", {7'd0, rsp_bus.pin_e}, {7'd0, want.e});
               check_field("data_out", rsp_bus.data_out, want.data_out);
               check_field("data_drive", {7'd0, rsp_bus.data_drive}, {7'd0, want.drive});
               check_field("ready_res", {7'd0, rsp_bus.ready_res}, {7'd0, want.ready_res});
               check_field("accepted", {7'd0, rsp_bus.accepted}, {7'd0, want.accepted});
            end
         end
      end
   end

   // Receiver stalls: drop rsp ready at random per the current phase
   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);

   // Drive one request transaction; call and return at a falling edge
   task automatic push_item(input lcd_request_type item, input logic typed,
                            input lcd_pins_type pins);
      while ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= item.command;
      req_bus.value   <= item.value;
      req_bus.line    <= item.line;
      req_bus.column  <= item.column;
      req_bus.bus_in  <= item.bus_in;
      drv_typed       <= typed;
      drv_pins        <= pins;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Hold off until every response is back; every item yields exactly one
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_pins.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // One write pulse; return a falling edge after the enable drops
   task automatic write_csr(input logic sel, input logic [19:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= sel;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      lcd_request_type item;
      int              item_total;
      int              req_pct;
      int              pick;
      logic [7:0]      en_ticks;

      req_bus.valid    = 1'b0;
      req_bus.command  = CMD_TICK;
      req_bus.value    = '0;
      req_bus.line     = '0;
      req_bus.column   = '0;
      req_bus.bus_in   = '0;
      rsp_bus.ready    = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_ENABLE_TICKS;
      csr_write_data   = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table, sender 24% idle, receiver 57% stalled
      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == ROW_CSR) begin
            wait_drained();
            write_csr(directed_steps[i].csr_sel, directed_steps[i].csr_value);
         end else begin
            push_item(directed_steps[i].item, directed_steps[i].typed, directed_steps[i].pins);
         end
      end

      // Random phases: swap the idling, then none; sweep enable_ticks incl. 0 and 255
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               send_gap_pct = 24; rsp_stall_pct = 57;
               en_ticks = 8'd1; item_total = 90; req_pct = 12;
            end
            1: begin
               send_gap_pct = 57; rsp_stall_pct = 24;
               en_ticks = 8'd0; item_total = 90; req_pct = 12;
            end
            2: begin
               send_gap_pct = 0; rsp_stall_pct = 0;
               en_ticks = 8'($urandom_range(6, 2)); item_total = 60; req_pct = 12;
            end
            default: begin
               // long levels: mostly ticks so a full high level runs out
               send_gap_pct = 0; rsp_stall_pct = 0;
               en_ticks = 8'd255; item_total = 270; req_pct = 3;
            end
         endcase
         wait_drained();
         write_csr(CSR_ENABLE_TICKS, {12'd0, en_ticks});
         if (p == 2)
            write_csr(CSR_POWERUP_TICKS, 20'($urandom_range(20'hFFFFF, 1)));
         repeat (item_total) begin
            item.value  = 8'($urandom_range(255));
            item.line   = 2'($urandom_range(3));
            item.column = 6'($urandom_range(63));
            item.bus_in = 8'($urandom_range(255));
            // busy about a third of the time so polls repeat but finish
            item.bus_in[7] = ($urandom_range(99) < 30);
            // favor requests while idle so most get taken; the rest are refused
            if ($urandom_range(99) < ((lcd_phase == PH_IDLE) ? 60 : req_pct)) begin
               pick = int'($urandom_range(2));
               item.command = (pick == 0) ? CMD_DATA : (pick == 1) ? CMD_INSTR : CMD_POS;
            end else begin
               item.command = CMD_TICK;
            end
            push_item(item, 1'b0, PINS_QUIET);
         end
      end

      wait_drained();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0)
         $display("PASS char_lcd_bus_sequencer");
      else
         $display("FAIL char_lcd_bus_sequencer");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("FAIL char_lcd_bus_sequencer");
      $finish;
   end

endmodule
